@@ hw/rtl/ust_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ust_pkg: shared types and constants of the split completion tracker
// holds register codes, action codes, beat structs and the attempt-end rule
// ----------------------------------------------------------------------------
package ust_pkg;

  localparam int unsigned ATT_W   = 4;
  localparam int unsigned SPLIT_W = 8;
  localparam int unsigned POLL_W  = 17;

  // register indexes on the config port
  localparam logic [1:0] REG_RETRY_LIMIT       = 2'd0;
  localparam logic [1:0] REG_SPLIT_RETRY_LIMIT = 2'd1;
  localparam logic [1:0] REG_SPLIT_MODE        = 2'd2;
  localparam logic [1:0] REG_POLL_LIMIT        = 2'd3;

  localparam logic [ATT_W-1:0]   RETRY_LIMIT_RST       = 4'd5;
  localparam logic [SPLIT_W-1:0] SPLIT_RETRY_LIMIT_RST = 8'd100;
  localparam logic               SPLIT_MODE_RST        = 1'b0;
  localparam logic [POLL_W-1:0]  POLL_LIMIT_RST        = 17'd100000;

  typedef enum logic [2:0] {
    ACT_WAIT      = 3'd0,
    ACT_ENTER_CS  = 3'd1,
    ACT_REPEAT_CS = 3'd2,
    ACT_RESTART   = 3'd3,
    ACT_SUCCESS   = 3'd4,
    ACT_FAILURE   = 3'd5,
    ACT_IDLE      = 3'd6
  } ust_action_t;

  typedef struct packed {
    logic [ATT_W-1:0]   retry_limit;
    logic [SPLIT_W-1:0] split_retry_limit;
    logic               split_mode;
    logic [POLL_W-1:0]  poll_limit;
  } ust_cfg_t;

  typedef struct packed {
    logic               in_complete_phase;
    logic [SPLIT_W-1:0] split_retry_count;
    logic [ATT_W-1:0]   attempt_count;
    logic [POLL_W-1:0]  polls_left;
    logic               busy;
  } ust_state_t;

  typedef struct packed {
    logic func;
    logic xfer_done;
    logic halted;
    logic got_ack;
    logic got_nyet;
    logic got_nak;
    logic got_stall;
    logic xact_error;
    logic babble_error;
    logic bus_error;
  } ust_item_t;

  typedef struct packed {
    ust_action_t action;
    logic        clear_status;
    logic        complete_split;
  } ust_result_t;

  typedef struct packed {
    ust_state_t  st;
    ust_action_t act;
  } ust_ea_t;

  // end of one attempt: restart while attempts remain and the poll limit is nonzero, else fail
  function automatic ust_ea_t ust_end_attempt(ust_state_t s, ust_cfg_t c);
    ust_ea_t          r;
    logic [ATT_W:0]   nxt;
    r     = '{st: s, act: ACT_FAILURE};
    nxt   = {1'b0, s.attempt_count} + {{ATT_W{1'b0}}, 1'b1};
    r.st.attempt_count = nxt[ATT_W-1:0];
    if (nxt < {1'b0, c.retry_limit} && c.poll_limit != '0) begin
      if (c.split_mode) begin
        r.st.in_complete_phase = 1'b0;
      end
      r.st.split_retry_count = '0;
      r.st.polls_left        = c.poll_limit;
      r.act                  = ACT_RESTART;
    end else begin
      r.st.busy = 1'b0;
      r.act     = ACT_FAILURE;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/usb_split_completion_tracker_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// usb_split_completion_tracker_top: split transaction completion tracker
// follows one host channel transfer from polled status beats
// ----------------------------------------------------------------------------
// usage
//   in_* stream: one beat per channel status poll, or a start command
//     (in_tuser = 0 starts a transfer, 1 presents a status snapshot)
//   out_* stream: exactly one result beat per input beat, in order, giving
//     the action code, whether to clear channel status and the
//     complete-split bit to drive
//   cfg_* port: register writes land at the clock edge with cfg_we high and
//     act on the next beat decided; write only while no beat is in flight
// path: an accepted beat passes the input register, the decision logic and
//   the result register before it shows on out_*
// throughput: one beat per cycle while out_tready is high; the tracker state
//   updates in the same cycle the decision is made, so consecutive polls chain back to back
// stall: when out_tready is low the result register holds, the input
//   register still fills once, then in_tready drops until the result moves
// reset: rst_n low clears the valid bits of both pipeline registers, the tracker
//   state (idle, counters zero) and loads the register reset values
// ----------------------------------------------------------------------------
module usb_split_completion_tracker_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // status stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [0] xfer_done [1] halted [2] got_ack [3] got_nyet [4] got_nak
  // [5] got_stall [6] xact_error [7] babble_error [8] bus_error, rest zero
  input  wire logic [15:0] in_tdata,
  // [0] func
  input  wire logic        in_tuser,
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [2:0] action [3] clear_status [4] complete_split, rest zero
  output logic [7:0]       out_tdata,
  // register write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [16:0] cfg_wdata
);
  import ust_pkg::*;

  ust_cfg_t    cfg_r;
  ust_state_t  state_r;
  ust_state_t  state_nxt;
  ust_item_t   item_r;
  logic        item_valid_r;
  ust_result_t res_nxt;
  ust_result_t res_r;
  logic        out_valid_r;
  logic        advance;
  logic        in_beat;

  // result register free or draining this cycle
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !item_valid_r || advance;
  assign in_beat   = in_tvalid && in_tready;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{retry_limit:       RETRY_LIMIT_RST,
                 split_retry_limit: SPLIT_RETRY_LIMIT_RST,
                 split_mode:        SPLIT_MODE_RST,
                 poll_limit:        POLL_LIMIT_RST};
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RETRY_LIMIT:       cfg_r.retry_limit       <= cfg_wdata[ATT_W-1:0];
        REG_SPLIT_RETRY_LIMIT: cfg_r.split_retry_limit <= cfg_wdata[SPLIT_W-1:0];
        REG_SPLIT_MODE:        cfg_r.split_mode        <= cfg_wdata[0];
        REG_POLL_LIMIT:        cfg_r.poll_limit        <= cfg_wdata[POLL_W-1:0];
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_tready) begin
      item_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      item_r <= '{func:         in_tuser,
                  xfer_done:    in_tdata[0],
                  halted:       in_tdata[1],
                  got_ack:      in_tdata[2],
                  got_nyet:     in_tdata[3],
                  got_nak:      in_tdata[4],
                  got_stall:    in_tdata[5],
                  xact_error:   in_tdata[6],
                  babble_error: in_tdata[7],
                  bus_error:    in_tdata[8]};
    end
  end

  ust_decide u_decide (
    .cfg  (cfg_r),
    .cur  (state_r),
    .item (item_r),
    .nxt  (state_nxt),
    .res  (res_nxt)
  );

  // tracker state moves only when a decided beat enters the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (item_valid_r && advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= item_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid_r && advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, res_r.complete_split, res_r.clear_status, res_r.action};

  // a decided beat always lands in the result register
  a_beat_to_result : assert property (@(posedge clk) disable iff (!rst_n)
    item_valid_r && advance |=> out_valid_r)
    else $error("decided beat lost before result register");

  // the transfer only ends with a success or failure result
  a_busy_end : assert property (@(posedge clk) disable iff (!rst_n)
    $fell(state_r.busy) |-> out_valid_r &&
      (res_r.action == ACT_SUCCESS || res_r.action == ACT_FAILURE))
    else $error("transfer ended without success or failure");

  // an active transfer always has polls left in its budget
  a_poll_budget : assert property (@(posedge clk) disable iff (!rst_n)
    state_r.busy |-> state_r.polls_left != '0)
    else $error("busy with empty poll budget");

  // no result code beyond idle is ever presented, and the unused upper bits stay zero
  a_action_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_tdata[2:0] != 3'd7 && out_tdata[7:5] == 3'b000)
    else $error("malformed result beat");

endmodule

`default_nettype wire

@@ hw/rtl/ust_decide.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ust_decide: per-beat decision logic
// maps tracker state, registers and one status beat to next state and result
// ----------------------------------------------------------------------------
module ust_decide (
  input  ust_pkg::ust_cfg_t    cfg,
  input  ust_pkg::ust_state_t  cur,
  input  ust_pkg::ust_item_t   item,
  output ust_pkg::ust_state_t  nxt,
  output ust_pkg::ust_result_t res
);
  import ust_pkg::*;

  ust_state_t  st;
  ust_action_t act;
  ust_ea_t     ea_halt;
  ust_ea_t     ea_poll;
  logic        clr;
  logic        consume;
  logic        handled;
  logic        err;
  logic        split_ok;

  assign err      = item.got_stall | item.xact_error | item.babble_error | item.bus_error;
  assign split_ok = cur.split_retry_count < cfg.split_retry_limit;

  always_comb begin
    st      = cur;
    act     = ACT_WAIT;
    clr     = 1'b0;
    consume = 1'b0;
    handled = 1'b0;
    ea_halt = ust_end_attempt(cur, cfg);
    if (!item.func) begin
      st.in_complete_phase = 1'b0;
      st.split_retry_count = '0;
      st.attempt_count     = '0;
      st.polls_left        = cfg.poll_limit;
      st.busy              = 1'b1;
      if (cfg.retry_limit == '0 || cfg.poll_limit == '0) begin
        st.busy = 1'b0;
        act     = ACT_FAILURE;
      end
    end else if (!cur.busy) begin
      act = ACT_IDLE;
    end else if (item.xfer_done) begin
      clr = 1'b1;
      if (cfg.split_mode) begin
        st.in_complete_phase = 1'b0;
      end
      st.busy = 1'b0;
      act     = ACT_SUCCESS;
    end else if (item.halted) begin
      if (cfg.split_mode) begin
        priority if (!cur.in_complete_phase && (item.got_ack || item.got_nyet)) begin
          handled = 1'b1;
          if (split_ok) begin
            clr                  = 1'b1;
            st.in_complete_phase = 1'b1;
            st.split_retry_count = cur.split_retry_count + 1'b1;
            act                  = ACT_ENTER_CS;
            consume              = 1'b1;
          end else begin
            st  = ea_halt.st;
            act = ea_halt.act;
          end
        end else if (cur.in_complete_phase && item.got_nyet) begin
          handled = 1'b1;
          if (split_ok) begin
            clr                  = 1'b1;
            st.split_retry_count = cur.split_retry_count + 1'b1;
            act                  = ACT_REPEAT_CS;
            consume              = 1'b1;
          end else begin
            st  = ea_halt.st;
            act = ea_halt.act;
          end
        end else if (cur.in_complete_phase && item.got_ack) begin
          handled              = 1'b1;
          clr                  = 1'b1;
          st.in_complete_phase = 1'b0;
          st.busy              = 1'b0;
          act                  = ACT_SUCCESS;
        end else if (item.got_nak) begin
          // in split mode the end of attempt drops the phase bit only on a restart, so clear it here
          handled = 1'b1;
          clr     = 1'b1;
          st      = ea_halt.st;
          st.in_complete_phase = 1'b0;
          act     = ea_halt.act;
        end else begin
          handled = 1'b0;
        end
      end else begin
        if (item.got_ack) begin
          handled = 1'b1;
          clr     = 1'b1;
          st.busy = 1'b0;
          act     = ACT_SUCCESS;
        end else if (item.got_nak) begin
          handled = 1'b1;
          clr     = 1'b1;
          st      = ea_halt.st;
          act     = ea_halt.act;
        end
      end
      if (!handled) begin
        clr = 1'b1;
        if (cfg.split_mode) begin
          st.in_complete_phase = 1'b0;
        end
        st.busy = 1'b0;
        act     = err ? ACT_FAILURE : ACT_SUCCESS;
      end
    end else if (err) begin
      clr     = 1'b1;
      st.busy = 1'b0;
      act     = ACT_FAILURE;
    end else begin
      consume = 1'b1;
    end

    // poll budget: the last poll turns the decision into an attempt end
    if (consume && st.polls_left != '0) begin
      st.polls_left = st.polls_left - 1'b1;
    end
    ea_poll = ust_end_attempt(st, cfg);
    if (consume && st.polls_left == '0) begin
      st  = ea_poll.st;
      act = ea_poll.act;
    end

    nxt = st;
    res = '{action: act, clear_status: clr, complete_split: st.in_complete_phase};
  end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb: self-checking bench of the split transaction completion tracker
// streams start commands and channel status polls through the tracker under
// random gaps and back pressure, predicts every result beat from its own model
// of the attempt, split and poll counters, and compares field by field
// ----------------------------------------------------------------------------
module tb;
  import ust_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned MAX_SHOWN   = 10;

  // kinds of status poll the random part draws from
  typedef enum int {
    PK_WAIT, PK_ACK, PK_NYET, PK_BOTH, PK_NAK,
    PK_HALT_ERR, PK_HALT_BARE, PK_DONE, PK_ERR, PK_NOISE
  } poll_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_RETRY_LIMIT;
  logic [16:0] cfg_wdata = '0;

  usb_split_completion_tracker_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register copies, kept in step with every write on the cfg port
  logic [ATT_W-1:0]   lim_retry  = RETRY_LIMIT_RST;
  logic [SPLIT_W-1:0] lim_split  = SPLIT_RETRY_LIMIT_RST;
  logic               mode_split = SPLIT_MODE_RST;
  logic [POLL_W-1:0]  lim_poll   = POLL_LIMIT_RST;

  // transfer tracking state as the tracker should hold it
  logic               cs_phase    = 1'b0;
  logic [SPLIT_W-1:0] split_cnt   = '0;
  logic [ATT_W-1:0]   attempt_cnt = '0;
  logic [POLL_W-1:0]  polls_rem   = '0;
  logic               busy        = 1'b0;

  ust_item_t   status_beats[$];      // beats waiting to be sent
  ust_result_t pending_decisions[$]; // decisions not yet seen on out_*

  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  int unsigned beats_sent = 0;
  int unsigned phases     = 0;
  int unsigned act_seen[0:6];
  bit          quiet      = 1'b0;    // no gaps or stalls in this phase
  bit          in_fire    = 1'b0;
  int unsigned in_gap     = 0;
  int unsigned out_gap    = 0;
  ust_item_t   drv_item;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // closes the current attempt: another try while attempts remain and the poll limit is nonzero, else give up
  function automatic ust_action_t close_attempt();
    logic [ATT_W:0] nxt;
    nxt = {1'b0, attempt_cnt} + 1'b1;
    attempt_cnt = nxt[ATT_W-1:0];
    if (nxt < {1'b0, lim_retry} && lim_poll != '0) begin
      if (mode_split) begin
        cs_phase = 1'b0;
      end
      split_cnt = '0;
      polls_rem = lim_poll;
      return ACT_RESTART;
    end
    busy = 1'b0;
    return ACT_FAILURE;
  endfunction

  // decision for one accepted beat; updates the tracking state
  function automatic ust_result_t decide_action(ust_item_t it);
    ust_result_t r;
    ust_action_t act;
    logic        clr;
    logic        spend;   // decision keeps the attempt alive and costs a poll
    logic        handled;
    logic        err;
    act     = ACT_WAIT;
    clr     = 1'b0;
    spend   = 1'b0;
    handled = 1'b0;
    err     = it.got_stall | it.xact_error | it.babble_error | it.bus_error;
    if (!it.func) begin
      // start: fresh transfer, status bits are ignored
      cs_phase    = 1'b0;
      split_cnt   = '0;
      attempt_cnt = '0;
      polls_rem   = lim_poll;
      busy        = 1'b1;
      if (lim_retry == '0 || lim_poll == '0) begin
        busy = 1'b0;
        act  = ACT_FAILURE;
      end
    end else if (!busy) begin
      act = ACT_IDLE;
    end else if (it.xfer_done) begin
      clr = 1'b1;
      if (mode_split) begin
        cs_phase = 1'b0;
      end
      busy = 1'b0;
      act  = ACT_SUCCESS;
    end else if (it.halted) begin
      if (mode_split) begin
        if (!cs_phase && (it.got_ack || it.got_nyet)) begin
          // start-split answered, go to complete-split
          handled = 1'b1;
          if (split_cnt < lim_split) begin
            clr       = 1'b1;
            cs_phase  = 1'b1;
            split_cnt = split_cnt + 1'b1;
            act       = ACT_ENTER_CS;
            spend     = 1'b1;
          end else begin
            act = close_attempt();
          end
        end else if (cs_phase && it.got_nyet) begin
          // hub not ready yet, repeat the complete-split
          handled = 1'b1;
          if (split_cnt < lim_split) begin
            clr       = 1'b1;
            split_cnt = split_cnt + 1'b1;
            act       = ACT_REPEAT_CS;
            spend     = 1'b1;
          end else begin
            act = close_attempt();
          end
        end else if (cs_phase && it.got_ack) begin
          handled  = 1'b1;
          clr      = 1'b1;
          cs_phase = 1'b0;
          busy     = 1'b0;
          act      = ACT_SUCCESS;
        end else if (it.got_nak) begin
          handled  = 1'b1;
          clr      = 1'b1;
          cs_phase = 1'b0;
          act      = close_attempt();
        end
      end else begin
        if (it.got_ack) begin
          handled = 1'b1;
          clr     = 1'b1;
          busy    = 1'b0;
          act     = ACT_SUCCESS;
        end else if (it.got_nak) begin
          handled = 1'b1;
          clr     = 1'b1;
          act     = close_attempt();
        end
      end
      // halt with no handled reason: errors fail, anything else succeeds
      if (!handled) begin
        clr = 1'b1;
        if (mode_split) begin
          cs_phase = 1'b0;
        end
        busy = 1'b0;
        act  = err ? ACT_FAILURE : ACT_SUCCESS;
      end
    end else if (err) begin
      // error bits without a halt, complete-split bit left alone
      clr  = 1'b1;
      busy = 1'b0;
      act  = ACT_FAILURE;
    end else begin
      spend = 1'b1;
    end
    // poll budget: the last poll turns the decision into an attempt end
    if (spend) begin
      if (polls_rem != '0) begin
        polls_rem = polls_rem - 1'b1;
      end
      if (polls_rem == '0) begin
        act = close_attempt();
      end
    end
    r.action         = act;
    r.clear_status   = clr;
    r.complete_split = cs_phase;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // gap length, mostly short and now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // errs: [0] stall [1] xact [2] babble [3] bus
  function automatic ust_item_t poll(logic done, logic halt, logic ack, logic nyet,
                                     logic nak, logic [3:0] errs);
    ust_item_t it;
    it.func         = 1'b1;
    it.xfer_done    = done;
    it.halted       = halt;
    it.got_ack      = ack;
    it.got_nyet     = nyet;
    it.got_nak      = nak;
    it.got_stall    = errs[0];
    it.xact_error   = errs[1];
    it.babble_error = errs[2];
    it.bus_error    = errs[3];
    return it;
  endfunction

  // start command, status bits carry random junk that must be ignored
  function automatic ust_item_t start_cmd();
    ust_item_t it;
    it      = ust_item_t'($urandom_range(0, 511));
    it.func = 1'b0;
    return it;
  endfunction

  function automatic ust_item_t random_poll();
    int unsigned w;
    poll_kind_t  k;
    logic [3:0]  noise_err;
    w = $urandom_range(0, 99);
    if      (w < 30) k = PK_WAIT;
    else if (w < 45) k = PK_ACK;
    else if (w < 60) k = PK_NYET;
    else if (w < 66) k = PK_BOTH;
    else if (w < 76) k = PK_NAK;
    else if (w < 81) k = PK_HALT_ERR;
    else if (w < 85) k = PK_HALT_BARE;
    else if (w < 89) k = PK_DONE;
    else if (w < 94) k = PK_ERR;
    else             k = PK_NOISE;
    // handled halts occasionally carry error bits too
    noise_err = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(1, 15)) : 4'd0;
    case (k)
      PK_WAIT: begin
        return poll(1'b0, 1'b0, 1'($urandom), 1'($urandom), 1'($urandom), 4'd0);
      end
      PK_ACK:       return poll(1'b0, 1'b1, 1'b1, 1'b0, 1'($urandom), noise_err);
      PK_NYET:      return poll(1'b0, 1'b1, 1'b0, 1'b1, 1'($urandom), noise_err);
      PK_BOTH:      return poll(1'b0, 1'b1, 1'b1, 1'b1, 1'($urandom), noise_err);
      PK_NAK:       return poll(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, noise_err);
      PK_HALT_ERR:  return poll(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 4'($urandom_range(1, 15)));
      PK_HALT_BARE: return poll(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 4'd0);
      PK_DONE: begin
        return poll(1'b1, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                    4'($urandom));
      end
      PK_ERR: begin
        return poll(1'b0, 1'b0, 1'($urandom), 1'($urandom), 1'($urandom),
                    4'($urandom_range(1, 15)));
      end
      default: begin
        return poll(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                    1'($urandom), 4'($urandom));
      end
    endcase
  endfunction

  // one transfer: a start and a run of polls; a few runs lack the start
  task automatic queue_transfer(inout int unsigned n);
    int unsigned polls;
    if ($urandom_range(0, 19) != 0) begin
      status_beats.push_back(start_cmd());
      n++;
    end
    polls = $urandom_range(1, 12);
    repeat (polls) begin
      status_beats.push_back(random_poll());
      n++;
    end
  endtask

  // all four registers, written one per cycle while the tracker is idle
  task automatic set_regs(logic [ATT_W-1:0] retry, logic [SPLIT_W-1:0] split,
                          logic mode, logic [POLL_W-1:0] polls);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_RETRY_LIMIT;
    cfg_wdata <= 17'(retry);
    @(negedge clk);
    cfg_index <= REG_SPLIT_RETRY_LIMIT;
    cfg_wdata <= 17'(split);
    @(negedge clk);
    cfg_index <= REG_SPLIT_MODE;
    cfg_wdata <= 17'(mode);
    @(negedge clk);
    cfg_index <= REG_POLL_LIMIT;
    cfg_wdata <= 17'(polls);
    @(negedge clk);
    cfg_we     <= 1'b0;
    lim_retry  = retry;
    lim_split  = split;
    mode_split = mode;
    lim_poll   = polls;
    phases++;
  endtask

  // wait until every beat is sent and every decision has come back
  task automatic drain();
    @(negedge clk);
    while (status_beats.size() != 0 || in_tvalid || pending_decisions.size() != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // driver: one beat in flight, gaps drawn after each accepted beat
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (in_gap != 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (status_beats.size() != 0) begin
        drv_item = status_beats.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= drv_item.func;
        in_tdata  <= {7'd0, drv_item.bus_error, drv_item.babble_error,
                      drv_item.xact_error, drv_item.got_stall, drv_item.got_nak,
                      drv_item.got_nyet, drv_item.got_ack, drv_item.halted,
                      drv_item.xfer_done};
        in_gap = pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result side back pressure
  always @(negedge clk) begin
    if (out_gap != 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      out_gap = pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: checks result beats, predicts on accepted input beats
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    ust_item_t   seen;
    ust_result_t want;
    ust_result_t got;
    in_fire <= in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.action         = ust_action_t'(out_tdata[2:0]);
        got.clear_status   = out_tdata[3];
        got.complete_split = out_tdata[4];
        if (pending_decisions.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN) begin
            $display("[%0d] unexpected result beat: action %0d clear %b cs %b",
                     cycles, out_tdata[2:0], got.clear_status, got.complete_split);
          end
        end else begin
          want = pending_decisions.pop_front();
          act_seen[int'(want.action)]++;
          if (got.action !== want.action || got.clear_status !== want.clear_status ||
              got.complete_split !== want.complete_split) begin
            mismatches++;
            if (mismatches <= MAX_SHOWN) begin
              $display("[%0d] mismatch: act exp %0d got %0d, clr exp %b got %b, cs exp %b got %b",
                       cycles, want.action, out_tdata[2:0], want.clear_status,
                       got.clear_status, want.complete_split, got.complete_split);
            end
          end
        end
      end
      if (in_tvalid && in_tready) begin
        seen.func         = in_tuser;
        seen.xfer_done    = in_tdata[0];
        seen.halted       = in_tdata[1];
        seen.got_ack      = in_tdata[2];
        seen.got_nyet     = in_tdata[3];
        seen.got_nak      = in_tdata[4];
        seen.got_stall    = in_tdata[5];
        seen.xact_error   = in_tdata[6];
        seen.babble_error = in_tdata[7];
        seen.bus_error    = in_tdata[8];
        pending_decisions.push_back(decide_action(seen));
        beats_sent++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d decisions outstanding",
               cycles, pending_decisions.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned n;
    int unsigned target;
    logic [ATT_W-1:0]   r_lim;
    logic [SPLIT_W-1:0] s_lim;
    logic [POLL_W-1:0]  p_lim;
    logic               s_mode;
    int unsigned        pick;
    foreach (act_seen[i]) act_seen[i] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // register reset values, split mode off
    status_beats.push_back(poll(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0));  // idle poll
    status_beats.push_back(poll(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 4'hf));  // idle, all set
    status_beats.push_back(start_cmd());
    status_beats.push_back(poll(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 4'd0));  // unhalted: wait
    status_beats.push_back(poll(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 4'd0));  // nak: restart
    status_beats.push_back(poll(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0));  // ack: success
    status_beats.push_back(start_cmd());
    status_beats.push_back(poll(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'b0001)); // unhalted stall
    status_beats.push_back(start_cmd());
    status_beats.push_back(poll(1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 4'hf));  // done wins
    status_beats.push_back(start_cmd());
    status_beats.push_back(poll(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 4'b0110)); // halt + errors
    status_beats.push_back(start_cmd());
    status_beats.push_back(poll(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 4'd0));  // other halt
    drain();

    // split mode, tight budgets: every split action plus poll exhaustion
    set_regs(4'd2, 8'd2, 1'b1, 17'd3);
    status_beats.push_back(start_cmd());
    status_beats.push_back(poll(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0));  // enter cs
    status_beats.push_back(poll(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 4'd0));  // nyet: repeat
    status_beats.push_back(poll(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 4'd0));  // split limit
    status_beats.push_back(poll(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 4'd0));  // enter cs
    status_beats.push_back(poll(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0));  // wait
    status_beats.push_back(poll(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0));  // last poll used
    status_beats.push_back(start_cmd());
    status_beats.push_back(poll(1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 4'd0));  // nak: restart
    status_beats.push_back(poll(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0));  // enter cs
    status_beats.push_back(poll(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0));  // cs ack: success
    drain();

    // zero retry limit, then zero poll limit: the start fails at once
    set_regs(4'd0, 8'd1, 1'b0, 17'd1);
    status_beats.push_back(start_cmd());
    status_beats.push_back(poll(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd0));
    drain();
    set_regs(4'd15, 8'd255, 1'b1, 17'd0);
    status_beats.push_back(start_cmd());
    status_beats.push_back(poll(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 4'd0));
    drain();

    // random phases: the first two at the extremes, the rest drawn
    for (int p = 0; p < 12; p++) begin
      if (p == 0) begin
        r_lim = 4'd15; s_lim = 8'd255; s_mode = 1'b1; p_lim = 17'd131071;
      end else if (p == 1) begin
        r_lim = 4'd1; s_lim = 8'd1; s_mode = 1'b1; p_lim = 17'd1;
      end else begin
        pick  = $urandom_range(0, 9);
        r_lim = (pick == 0) ? 4'd1 : (pick == 1) ? 4'd15 : 4'($urandom_range(1, 6));
        pick  = $urandom_range(0, 9);
        s_lim = (pick == 0) ? 8'd1 : (pick == 1) ? 8'd255 : 8'($urandom_range(1, 4));
        s_mode = ($urandom_range(0, 3) != 0);
        pick  = $urandom_range(0, 9);
        if (pick == 0)      p_lim = 17'd1;
        else if (pick == 1) p_lim = 17'd131071;
        else if (pick < 5)  p_lim = 17'($urandom_range(1, 4));
        else                p_lim = 17'($urandom_range(5, 30));
      end
      quiet = (p % 4 == 3);
      set_regs(r_lim, s_lim, s_mode, p_lim);
      n      = 0;
      target = 63;
      while (n < target) begin
        queue_transfer(n);
      end
      drain();
    end
    quiet = 1'b0;

    // trailing cycles so a stray extra beat would still be caught
    repeat (10) @(posedge clk);
    if (pending_decisions.size() != 0) begin
      mismatches++;
      $display("%0d decisions never arrived", pending_decisions.size());
    end
    $display("covered %0d beats over %0d register settings, %0d mismatches",
             beats_sent, phases, mismatches);
    $display("actions: wait %0d enter %0d repeat %0d restart %0d success %0d fail %0d idle %0d",
             act_seen[0], act_seen[1], act_seen[2], act_seen[3], act_seen[4],
             act_seen[5], act_seen[6]);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
